/* sv/sbar_pkg.sv */
// shared types, constants and helpers for the alternate block reverser
package sbar_pkg;

    localparam int MAX_BLOCK = 64;
    localparam int ADDR_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int K_W       = $clog2(MAX_BLOCK + 1);
    localparam int CHAR_W    = 8;
    localparam int CFG_W     = 7;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              is_final;
    } sbar_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              run_last;
        logic              string_end;
    } sbar_out_t;

    // controller to datapath
    typedef struct packed {
        logic take;     // input transaction completes this cycle
        logic rd_en;    // read the hold buffer at the burst index
        logic emit;     // load buffer read data into the output register
    } sbar_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pass_phase;
        logic burst_trig;
        logic out_free;
        logic rd_last;
    } sbar_sts_t;

    // clamp the written length into 1..MAX_BLOCK
    function automatic logic [K_W-1:0] eff_k(input logic [CFG_W-1:0] len);
        logic [K_W-1:0] k;
        if (32'(len) > 32'(MAX_BLOCK))
        begin
            k = K_W'(MAX_BLOCK);
        end
        else if (len == '0)
        begin
            k = K_W'(1);
        end
        else
        begin
            k = K_W'(len);
        end
        return k;
    endfunction

endpackage

/* sv/sbar_ram.sv */
// generic single-write, single-read ram with registered read data
module sbar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sbar_ctrl.sv */
// controller state machine for the alternate block reverser
module sbar_ctrl
    import sbar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sbar_sts_t sts,
    output sbar_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = sts.pass_phase && !sts.out_free;
                cmd.take = in_valid && !in_stall;
                if (cmd.take && !sts.pass_phase && sts.burst_trig)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.rd_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a burst-starting character always leads to a buffer read
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !sts.pass_phase && sts.burst_trig) |=> (state_reg == ST_READ))
        else $error("burst did not start after trigger");

    // the final burst character returns the controller to idle
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && sts.out_free && sts.rd_last) |=> (state_reg == ST_IDLE))
        else $error("burst did not end on last character");

    // nothing is taken in while a burst drains
    a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.take)
        else $error("input taken during burst");

endmodule

/* sv/sbar_dp.sv */
// datapath: hold buffer, counters, phase and output register
module sbar_dp
    import sbar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_len,
    input  sbar_in_t         in_data,
    output sbar_out_t        out_data,
    output logic             out_valid,
    input  logic             out_stall,
    input  sbar_cmd_t        cmd,
    output sbar_sts_t        sts
);

    logic [K_W-1:0]    blk_k_reg;
    logic [K_W-1:0]    fill_reg;
    logic [K_W-1:0]    fill_next;
    logic [K_W-1:0]    pass_reg;
    logic [K_W-1:0]    pass_next;
    logic              phase_reg;
    logic              phase_next;
    logic              fin_hold_reg;
    logic              fin_hold_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sbar_out_t         out_reg;
    sbar_out_t         out_next;

    logic [K_W-1:0]    fill_inc;
    logic [K_W-1:0]    pass_inc;
    logic              burst_trig;
    logic              out_free;
    logic              ram_we;
    logic [CHAR_W-1:0] ram_rdata;

    assign fill_inc   = fill_reg + K_W'(1);
    assign pass_inc   = pass_reg + K_W'(1);
    assign burst_trig = !phase_reg && ((fill_inc >= blk_k_reg) || in_data.is_final);
    assign out_free   = !out_valid_reg || !out_stall;
    assign ram_we     = cmd.take && !phase_reg;

    sbar_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_BLOCK)
    ) u_hold (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_data.in_char),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fill_next      = fill_reg;
        pass_next      = pass_reg;
        phase_next     = phase_reg;
        fin_hold_next  = fin_hold_reg;
        rd_idx_next    = rd_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.take)
        begin
            if (phase_reg)
            begin
                // pass-through half
                out_next.out_char   = in_data.in_char;
                out_next.run_last   = 1'b1;
                out_next.string_end = in_data.is_final;
                out_valid_next      = 1'b1;
                if ((pass_inc >= blk_k_reg) || in_data.is_final)
                begin
                    phase_next = 1'b0;
                    pass_next  = '0;
                end
                else
                begin
                    pass_next = pass_inc;
                end
                if (in_data.is_final)
                begin
                    fill_next = '0;
                end
            end
            else if (burst_trig)
            begin
                rd_idx_next   = fill_reg[ADDR_W-1:0];
                fill_next     = '0;
                pass_next     = '0;
                phase_next    = !in_data.is_final;
                fin_hold_next = in_data.is_final;
            end
            else
            begin
                fill_next = fill_inc;
            end
        end

        if (cmd.emit)
        begin
            out_next.out_char   = ram_rdata;
            out_next.run_last   = (rd_idx_reg == '0);
            out_next.string_end = (rd_idx_reg == '0) && fin_hold_reg;
            out_valid_next      = 1'b1;
            if (rd_idx_reg != '0)
            begin
                rd_idx_next = rd_idx_reg - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_k_reg     <= K_W'(1);
            fill_reg      <= '0;
            pass_reg      <= '0;
            phase_reg     <= 1'b0;
            fin_hold_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                blk_k_reg <= eff_k(cfg_len);
            end
            fill_reg      <= fill_next;
            pass_reg      <= pass_next;
            phase_reg     <= phase_next;
            fin_hold_reg  <= fin_hold_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_data = out_reg;
    assign out_valid = out_valid_reg;

    assign sts.pass_phase = phase_reg;
    assign sts.burst_trig = burst_trig;
    assign sts.out_free   = out_free;
    assign sts.rd_last    = (rd_idx_reg == '0);

    // the hold buffer never sits full between transactions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) < 32'(MAX_BLOCK))
        else $error("fill count reached buffer depth");

    // the pass-through half only runs with an empty hold buffer
    a_pass_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (fill_reg == '0))
        else $error("hold buffer not empty in pass phase");

    // an output load never collides with a stalled result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(cmd.emit || (cmd.take && phase_reg)))
        else $error("stalled result overwritten");

endmodule

/* sv/stream_block_alternate_reverser.sv */
// top level: reverse the first k characters of every 2k character group
// a pass-half character appears in the output the cycle after its transaction
// a burst of n held characters follows the character that completes it, each
// result a buffer read, then a load; input takes one character per cycle outside
// bursts, in the pass half only while the output is free; reset clears counters,
// phase and output valid and sets k to 1; the hold buffer is not cleared
module stream_block_alternate_reverser
    import sbar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write channel, the block length k
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    // input character stream
    input  logic             in_valid,
    output logic             in_stall,
    input  sbar_in_t         in_data,
    // output character stream
    output logic             out_valid,
    input  logic             out_stall,
    output sbar_out_t        out_data
);

    sbar_cmd_t cmd;
    sbar_sts_t sts;

    // length writes go straight into the block length register, so the port never holds off
    assign cfg_ready = 1'b1;

    // sequencing: accept, then drain the reversed burst from the buffer
    sbar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, counters and the output register
    sbar_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_len   (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
